### hdl/stt_pkg.sv
// Shared types and constants for the source text tokenizer.
`default_nettype none
package stt_pkg;

    // Token kinds
    localparam logic [3:0] K_END    = 4'd0;
    localparam logic [3:0] K_IDENT  = 4'd1;
    localparam logic [3:0] K_ARROW  = 4'd2;
    localparam logic [3:0] K_FAT    = 4'd3;
    localparam logic [3:0] K_NUMBER = 4'd4;
    localparam logic [3:0] K_STRING = 4'd5;
    localparam logic [3:0] K_TRUE   = 4'd6;
    localparam logic [3:0] K_FALSE  = 4'd7;
    localparam logic [3:0] K_CHAR   = 4'd8;
    localparam logic [3:0] K_SYMBOL = 4'd9;

    localparam int FIELD_W = 24;

    // Token queue between scanner and output stage
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [3:0]         kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic [FIELD_W-1:0] line;
        logic [7:0]         bval;
        logic               bad;
    } t_token;

    // All tokens caused by one text byte: tok0, then tok1 when two is set
    typedef struct packed {
        logic   two;
        t_token tok1;
        t_token tok0;
    } t_entry;

endpackage
`default_nettype wire

### hdl/stt_front.sv
// Scanner: accepts text bytes, tracks lexer state and forms token entries.
`default_nettype none
module stt_front
    import stt_pkg::*;
#(
    parameter int POSITION_BITS = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_full,
    output logic             o_push,
    output t_entry           o_entry
);

    localparam int P     = POSITION_BITS;
    localparam int EXT_W = POSITION_BITS + FIELD_W;

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_SLASH   = 4'd1;
    localparam logic [3:0] M_COMMENT = 4'd2;
    localparam logic [3:0] M_IDENT   = 4'd3;
    localparam logic [3:0] M_STRING  = 4'd4;
    localparam logic [3:0] M_NUMBER  = 4'd5;
    localparam logic [3:0] M_MINUS   = 4'd6;
    localparam logic [3:0] M_EQUAL   = 4'd7;
    localparam logic [3:0] M_CHAR1   = 4'd8;
    localparam logic [3:0] M_CHAR2   = 4'd9;

    localparam logic [7:0] C_NUL   = 8'h00;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_DQ    = 8'h22;
    localparam logic [7:0] C_SQ    = 8'h27;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_DOT   = 8'h2E;
    localparam logic [7:0] C_SLASH = 8'h2F;
    localparam logic [7:0] C_EQUAL = 8'h3D;
    localparam logic [7:0] C_GT    = 8'h3E;
    localparam logic [7:0] C_UNDER = 8'h5F;

    localparam logic [39:0]        W_TRUE   = 40'h0074727565;
    localparam logic [39:0]        W_FALSE  = 40'h66616C7365;
    localparam logic [FIELD_W-1:0] LINE_MAX = {FIELD_W{1'b1}};

    logic [3:0]         r_mode,   n_mode;
    logic [P-1:0]       r_pos,    n_pos;
    logic [P-1:0]       r_lex,    n_lex;
    logic [FIELD_W-1:0] r_nl,     n_nl;
    logic [39:0]        r_prefix, n_prefix;
    logic [2:0]         r_wlen,   n_wlen;
    logic               r_us,     n_us;
    logic               r_per,    n_per;
    logic               r_bad,    n_bad;
    logic [7:0]         r_held,   n_held;

    logic   again, ended, has1, has2, accept;
    t_token e1, e2;
    logic [3:0] wkind;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    // Position to field width: low bits, zero extended when narrower
    function automatic logic [FIELD_W-1:0] fit(input logic [P-1:0] v);
        logic [EXT_W-1:0] tmp;
        tmp = {{FIELD_W{1'b0}}, v};
        return tmp[FIELD_W-1:0];
    endfunction

    function automatic t_token make_tok(input logic [3:0] kind, input logic [P-1:0] start,
                                        input logic [P-1:0] len, input logic [7:0] bval,
                                        input logic bad, input logic [FIELD_W-1:0] line);
        t_token t;
        t.kind   = kind;
        t.start  = fit(start);
        t.length = fit(len);
        t.line   = line;
        t.bval   = bval;
        t.bad    = bad;
        return t;
    endfunction

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        if (r_wlen == 3'd4 && r_prefix == W_TRUE) begin
            wkind = K_TRUE;
        end else if (r_wlen == 3'd5 && r_prefix == W_FALSE) begin
            wkind = K_FALSE;
        end else begin
            wkind = K_IDENT;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_pos    = P'(r_pos + 1'b1);
        n_lex    = r_lex;
        n_nl     = r_nl;
        n_prefix = r_prefix;
        n_wlen   = r_wlen;
        n_us     = r_us;
        n_per    = r_per;
        n_bad    = r_bad;
        n_held   = r_held;
        again    = 1'b0;
        ended    = 1'b0;
        has1     = 1'b0;
        has2     = 1'b0;
        e1       = '0;
        e2       = '0;

        // token in progress
        unique case (r_mode)
            M_SLASH: begin
                if (i_byte == C_SLASH) begin
                    n_mode = M_COMMENT;
                end else begin
                    has1  = 1'b1;
                    e1    = make_tok(K_SYMBOL, r_lex, P'(1), C_SLASH, 1'b0, r_nl);
                    again = 1'b1;
                end
            end
            M_COMMENT: begin
                again = (i_byte == C_NUL) || (i_byte == C_LF);
            end
            M_IDENT: begin
                if (is_alpha(i_byte) || is_digit(i_byte) || i_byte == C_UNDER) begin
                    if (r_wlen < 3'd5) begin
                        n_prefix = {r_prefix[31:0], i_byte};
                        n_wlen   = 3'(r_wlen + 1'b1);
                    end else begin
                        n_wlen = 3'd6;
                    end
                end else begin
                    has1  = 1'b1;
                    e1    = make_tok(wkind, r_lex, P'(r_pos - r_lex), 8'd0, 1'b0, r_nl);
                    again = 1'b1;
                end
            end
            M_STRING: begin
                if (i_byte == C_DQ) begin
                    has1   = 1'b1;
                    e1     = make_tok(K_STRING, r_lex, P'(r_pos - r_lex), 8'd0, 1'b0, r_nl);
                    n_mode = M_IDLE;
                end else if (i_byte == C_NUL) begin
                    has1  = 1'b1;
                    e1    = make_tok(K_STRING, r_lex, P'(r_pos - r_lex), 8'd0, 1'b1, r_nl);
                    again = 1'b1;
                end
            end
            M_NUMBER: begin
                if (i_byte == C_UNDER) begin
                    if (r_us) begin
                        n_bad = 1'b1;
                        again = 1'b1;
                    end else begin
                        n_us = 1'b1;
                    end
                end else begin
                    n_us = 1'b0;
                    if (i_byte == C_DOT) begin
                        if (r_per) begin
                            n_bad = 1'b1;
                            again = 1'b1;
                        end else begin
                            n_per = 1'b1;
                        end
                    end else if (!is_digit(i_byte)) begin
                        again = 1'b1;
                    end
                end
                if (again) begin
                    has1 = 1'b1;
                    e1   = make_tok(K_NUMBER, r_lex, P'(r_pos - r_lex), 8'd0, n_bad, r_nl);
                end
            end
            M_MINUS, M_EQUAL: begin
                if (i_byte == C_GT) begin
                    has1   = 1'b1;
                    e1     = make_tok((r_mode == M_MINUS) ? K_ARROW : K_FAT, r_lex, P'(2),
                                      8'd0, 1'b0, r_nl);
                    n_mode = M_IDLE;
                end else begin
                    has1  = 1'b1;
                    e1    = make_tok(K_SYMBOL, r_lex, P'(1),
                                     (r_mode == M_MINUS) ? C_MINUS : C_EQUAL, 1'b0, r_nl);
                    again = 1'b1;
                end
            end
            M_CHAR1: begin
                if (i_byte == C_NUL) begin
                    again = 1'b1;
                end else begin
                    n_held = i_byte;
                    n_mode = M_CHAR2;
                end
            end
            M_CHAR2: begin
                if (i_byte == C_SQ) begin
                    has1   = 1'b1;
                    e1     = make_tok(K_CHAR, r_lex, P'(1), r_held, 1'b0, r_nl);
                    n_mode = M_IDLE;
                end else begin
                    again = 1'b1;
                end
            end
            default: begin
                again = 1'b1;
            end
        endcase

        // byte scanned afresh, as between tokens
        if (again) begin
            n_mode = M_IDLE;
            priority if (i_byte == C_SPACE || i_byte == C_TAB) begin
                n_mode = M_IDLE;
            end else if (i_byte == C_LF) begin
                if (r_nl != LINE_MAX) begin
                    n_nl = FIELD_W'(r_nl + 1'b1);
                end
            end else if (i_byte == C_NUL) begin
                has2  = 1'b1;
                e2    = make_tok(K_END, r_pos, '0, 8'd0, 1'b0, r_nl);
                ended = 1'b1;
            end else begin
                n_lex = r_pos;
                priority if (i_byte == C_SLASH) begin
                    n_mode = M_SLASH;
                end else if (is_alpha(i_byte)) begin
                    n_mode   = M_IDENT;
                    n_prefix = {32'd0, i_byte};
                    n_wlen   = 3'd1;
                end else if (i_byte == C_DQ) begin
                    n_mode = M_STRING;
                    n_lex  = P'(r_pos + 1'b1);
                end else if (is_digit(i_byte)) begin
                    n_mode = M_NUMBER;
                    n_us   = 1'b0;
                    n_per  = 1'b0;
                    n_bad  = 1'b0;
                end else if (i_byte == C_MINUS) begin
                    n_mode = M_MINUS;
                end else if (i_byte == C_EQUAL) begin
                    n_mode = M_EQUAL;
                end else if (i_byte == C_SQ) begin
                    n_mode = M_CHAR1;
                    n_lex  = P'(r_pos + 1'b1);
                end else begin
                    has2 = 1'b1;
                    e2   = make_tok(K_SYMBOL, r_pos, P'(1), i_byte, 1'b0, r_nl);
                end
            end
        end

        // end of text returns everything to reset values
        if (ended) begin
            n_mode   = M_IDLE;
            n_pos    = '0;
            n_lex    = '0;
            n_nl     = '0;
            n_prefix = '0;
            n_wlen   = '0;
            n_us     = 1'b0;
            n_per    = 1'b0;
            n_bad    = 1'b0;
            n_held   = '0;
        end
    end

    always_comb begin
        o_push       = accept && (has1 || has2);
        o_entry.two  = has1 && has2;
        o_entry.tok0 = has1 ? e1 : e2;
        o_entry.tok1 = e2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_pos    <= '0;
            r_lex    <= '0;
            r_nl     <= '0;
            r_prefix <= '0;
            r_wlen   <= '0;
            r_us     <= 1'b0;
            r_per    <= 1'b0;
            r_bad    <= 1'b0;
            r_held   <= '0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_lex    <= n_lex;
            r_nl     <= n_nl;
            r_prefix <= n_prefix;
            r_wlen   <= n_wlen;
            r_us     <= n_us;
            r_per    <= n_per;
            r_bad    <= n_bad;
            r_held   <= n_held;
        end
    end

endmodule
`default_nettype wire

### hdl/stt_queue.sv
// Short queue of token entries between scanner and output stage.
`default_nettype none
module stt_queue
    import stt_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output t_entry      o_entry,
    output logic        o_full,
    output logic        o_empty
);

    localparam logic [Q_PTR_W-1:0] PTR_LAST = Q_PTR_W'(Q_DEPTH - 1);
    localparam logic [Q_CNT_W-1:0] CNT_FULL = Q_CNT_W'(Q_DEPTH);

    t_entry              r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr, r_rd;
    logic [Q_CNT_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : Q_PTR_W'(r_wr + 1'b1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : Q_PTR_W'(r_rd + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= Q_CNT_W'(r_cnt + 1'b1);
            end else if (i_pop && !i_push) begin
                r_cnt <= Q_CNT_W'(r_cnt - 1'b1);
            end
        end
    end

endmodule
`default_nettype wire

### hdl/stt_back.sv
// Output stage: unpacks queue entries into single tokens in an output register.
`default_nettype none
module stt_back
    import stt_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_entry i_entry,
    input  wire logic   i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_token      o_tok,
    output logic        o_last
);

    logic   r_valid;
    logic   r_sel;
    logic   r_last;
    t_token r_tok;
    logic   out_free, load, head_last;

    assign out_free  = !r_valid || i_ready;
    assign load      = out_free && !i_empty;
    assign head_last = !i_entry.two || r_sel;
    assign o_pop     = load && head_last;

    assign o_valid = r_valid;
    assign o_tok   = r_tok;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok  <= r_sel ? i_entry.tok1 : i_entry.tok0;
            r_last <= head_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (out_free) begin
            r_valid <= !i_empty;
            if (load) begin
                r_sel <= !head_last;
            end
        end
    end

endmodule
`default_nettype wire

### hdl/source_text_tokenizer_top.sv
// Top level of the source text tokenizer: scanner, token queue and output stage.
`default_nettype none
// Source text enters one byte per word on the slave stream; a zero byte ends
// the text, emits the end token and returns the scanner to its reset state.
// The scanner takes a byte every cycle while its queue has room and turns it
// into zero, one or two tokens (a token that needs lookahead is reported on
// the byte after it, and that byte may start or be a token of its own).
// Tokens leave on the master stream one per word, through the token queue and
// the output register, with tlast set on the final token of that byte. The
// sustained rate is one byte per cycle while the master stream is ready; it is
// set by the output register, which moves one token per cycle, so a byte that
// yields two tokens takes two output words; the four-entry queue absorbs bursts.
// Positions count modulo 2^POSITION_BITS and are reported in 24 bits; the
// line count saturates at 2^24-1.
module source_text_tokenizer_top
    import stt_pkg::*;
#(
    parameter int POSITION_BITS = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,   // [23:0] token_start, [47:24] token_length,
                                             // [71:48] token_line, [79:72] byte_value
    output logic [4:0]       m_axis_tuser,   // [3:0] token_kind, [4] malformed
    output logic             m_axis_tlast    // last token caused by one text byte
);

    logic   w_push, w_pop, w_full, w_empty;
    t_entry w_in_entry, w_head;
    t_token w_tok;

    stt_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_in_entry)
    );

    // one entry per byte that produced tokens
    stt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_in_entry),
        .i_pop   (w_pop),
        .o_entry (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    stt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_tok   (w_tok),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {w_tok.bval, w_tok.line, w_tok.length, w_tok.start};
    assign m_axis_tuser = {w_tok.bad, w_tok.kind};

    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("token queue written while full");

    // no pop from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("token queue read while empty");

    // the end token is always the final token of its byte
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[3:0] == K_END) |-> m_axis_tlast)
        else $error("end token without tlast");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule
`default_nettype wire
